// ===== src/fys_pkg.sv =====
package fys_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEPTH_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 16;

    // fixed field widths of the beats
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int RAND_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int STEPS_W  = 10;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               first;
        logic [VALUE_W-1:0] value;
        logic [RAND_W-1:0]  rand_word;
        logic [INDEX_W-1:0] index;
    } t_in_beat;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic [STATUS_W-1:0] status;
        logic [STEPS_W-1:0]  steps_left;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted input beat
        logic decide;      // latch the result status of the held item
        logic load;        // append the held value
        logic step_start;  // start the remainder unit, read entry at position
        logic read;        // read entry at the held index
        logic swap_rd;     // keep entry at position, read entry j
        logic wr_pos;      // entry at position takes entry j
        logic wr_j;        // entry j takes old entry at position, step position down
        logic post;        // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              load_ok;
        logic              step_run;
        logic              read_ok;
        logic              div_busy;
        logic              out_free;
    } t_stat;

endpackage

// ===== src/fys_divmod.sv =====
module fys_divmod #(
    parameter int DSR_BITS = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fys_pkg::RAND_W-1:0] i_dividend,
    input  logic [DSR_BITS-1:0]       i_divisor,
    output logic                      o_busy,
    output logic [DSR_BITS-1:0]       o_rem
);

    localparam int CNTW = $clog2(fys_pkg::RAND_W);

    logic                       r_busy;
    logic [CNTW-1:0]            r_cnt;
    logic [fys_pkg::RAND_W-1:0] r_dvd;
    logic [DSR_BITS-1:0]        r_dsr;
    logic [DSR_BITS-1:0]        r_rem;

    logic [DSR_BITS:0]          w_trial;
    logic [DSR_BITS:0]          w_diff;
    logic [DSR_BITS-1:0]        n_rem;

    // restoring remainder, one dividend bit a cycle, msb first
    assign w_trial = {r_rem, r_dvd[fys_pkg::RAND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign n_rem   = (w_trial >= {1'b0, r_dsr}) ? w_diff[DSR_BITS-1:0]
                                                 : w_trial[DSR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNTW'(1);
            if (r_cnt == CNTW'(fys_pkg::RAND_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[fys_pkg::RAND_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

    a_rem_below_dsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && $past(r_busy)) |-> (r_rem < r_dsr))
        else $error("remainder not below divisor at end of run");

    a_start_clears_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_cnt == '0))
        else $error("remainder run did not restart");

endmodule

// ===== src/fys_datapath.sv =====
module fys_datapath #(
    parameter int DEPTH      = fys_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = fys_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fys_pkg::t_in_beat  i_in_data,
    input  fys_pkg::t_cmd      i_cmd,
    output fys_pkg::t_stat     o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output fys_pkg::t_out_beat o_out_data
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int DW  = AW + 1;
    localparam int IXW = (fys_pkg::INDEX_W > CW) ? fys_pkg::INDEX_W : CW;
    localparam int XW  = (fys_pkg::VALUE_W > VALUE_BITS) ? fys_pkg::VALUE_W : VALUE_BITS;
    localparam int SW  = (fys_pkg::STEPS_W > AW) ? fys_pkg::STEPS_W : AW;

    fys_pkg::t_in_beat          r_item;
    logic [CW-1:0]              r_count;
    logic [AW-1:0]              r_pos;
    logic [fys_pkg::STATUS_W-1:0] r_res_status;
    logic                       r_res_rd;
    logic [VALUE_BITS-1:0]      r_val_p;
    logic [VALUE_BITS-1:0]      r_rd_data;
    logic [VALUE_BITS-1:0]      r_mem [DEPTH];
    logic                       r_out_valid;
    fys_pkg::t_out_beat         r_out_data;

    logic [CW-1:0]              w_eff_count;
    logic                       w_load_ok;
    logic                       w_step_run;
    logic                       w_read_ok;
    logic [IXW-1:0]             w_idx_ext;
    logic [XW-1:0]              w_val_ext;
    logic [XW-1:0]              w_rd_ext;
    logic [SW-1:0]              w_pos_ext;
    logic [DW-1:0]              w_divisor;
    logic [DW-1:0]              w_rem;
    logic                       w_div_busy;
    logic [AW-1:0]              w_j;
    logic                       w_wr_en;
    logic [AW-1:0]              w_wr_addr;
    logic [VALUE_BITS-1:0]      w_wr_data;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    logic [fys_pkg::STATUS_W-1:0] n_res_status;
    fys_pkg::t_out_beat         n_out_data;

    // first load empties the store before the append
    assign w_eff_count = r_item.first ? '0 : r_count;
    assign w_load_ok   = (w_eff_count != CW'(DEPTH));
    assign w_step_run  = (r_pos != '0) && (CW'(r_pos) < r_count);
    assign w_idx_ext   = IXW'(r_item.index);
    assign w_read_ok   = (w_idx_ext < IXW'(r_count));
    assign w_val_ext   = XW'(r_item.value);
    assign w_rd_ext    = XW'(r_rd_data);
    assign w_pos_ext   = SW'(r_pos);

    assign w_divisor = DW'(r_pos) + DW'(1);
    assign w_j       = w_rem[AW-1:0];

    fys_divmod #(
        .DSR_BITS (DW)
    ) u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.step_start),
        .i_dividend (r_item.rand_word),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_rem      (w_rem)
    );

    // single write port
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_eff_count[AW-1:0];
        w_wr_data = w_val_ext[VALUE_BITS-1:0];
        if (i_cmd.load) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.wr_pos) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_pos;
            w_wr_data = r_rd_data;
        end else if (i_cmd.wr_j) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_j;
            w_wr_data = r_val_p;
        end
    end

    // single read port
    always_comb begin
        w_rd_en = i_cmd.step_start | i_cmd.read | i_cmd.swap_rd;
        if (i_cmd.read) begin
            w_rd_addr = w_idx_ext[AW-1:0];
        end else if (i_cmd.swap_rd) begin
            w_rd_addr = w_j;
        end else begin
            w_rd_addr = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        case (r_item.func)
            fys_pkg::FUNC_LOAD: n_res_status = w_load_ok  ? fys_pkg::ST_OK : fys_pkg::ST_FULL;
            fys_pkg::FUNC_STEP: n_res_status = w_step_run ? fys_pkg::ST_OK : fys_pkg::ST_DONE;
            fys_pkg::FUNC_READ: n_res_status = w_read_ok  ? fys_pkg::ST_OK : fys_pkg::ST_RANGE;
            default:            n_res_status = fys_pkg::ST_OK;
        endcase
    end

    always_comb begin
        n_out_data.value_out  = r_res_rd ? w_rd_ext[fys_pkg::VALUE_W-1:0] : '0;
        n_out_data.status     = r_res_status;
        n_out_data.steps_left = w_pos_ext[fys_pkg::STEPS_W-1:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count <= w_eff_count + CW'(1);
                r_pos   <= w_eff_count[AW-1:0];
            end else if (i_cmd.wr_j) begin
                r_pos <= r_pos - AW'(1);
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.decide) begin
            r_res_status <= n_res_status;
            r_res_rd     <= (r_item.func == fys_pkg::FUNC_READ) && w_read_ok;
        end
        if (i_cmd.swap_rd) begin
            r_val_p <= r_rd_data;
        end
        if (i_cmd.post) begin
            r_out_data <= n_out_data;
        end
    end

    always_comb begin
        o_stat.func     = r_item.func;
        o_stat.load_ok  = w_load_ok;
        o_stat.step_run = w_step_run;
        o_stat.read_ok  = w_read_ok;
        o_stat.div_busy = w_div_busy;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) || (CW'(r_pos) < r_count))
        else $error("position not below entry count");

endmodule

// ===== src/fys_ctrl.sv =====
module fys_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fys_pkg::t_stat i_stat,
    output fys_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_DIV    = 6'b000100,
        S_WRP    = 6'b001000,
        S_WRJ    = 6'b010000,
        S_POST   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_POST;
                case (i_stat.func)
                    fys_pkg::FUNC_LOAD: o_cmd.load = i_stat.load_ok;
                    fys_pkg::FUNC_STEP: begin
                        if (i_stat.step_run) begin
                            o_cmd.step_start = 1'b1;
                            n_state          = S_DIV;
                        end
                    end
                    fys_pkg::FUNC_READ: o_cmd.read = i_stat.read_ok;
                    default:            o_cmd.read = 1'b0;
                endcase
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.swap_rd = 1'b1;
                    n_state       = S_WRP;
                end
            end
            S_WRP: begin
                o_cmd.wr_pos = 1'b1;
                n_state      = S_WRJ;
            end
            S_WRJ: begin
                o_cmd.wr_j = 1'b1;
                n_state    = S_POST;
            end
            S_POST: begin
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_div_to_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_stat.div_busy) |=> (r_state == S_WRP))
        else $error("swap did not follow remainder");

endmodule

// ===== src/fisher_yates_shuffle_core.sv =====
// channel   direction  handshake                   payload
// --------  ---------  --------------------------  ---------------------------------
// input     in         i_in_valid / o_in_ready     i_in_data  (func first value
//                                                  rand_word index)
// result    out        o_out_valid / i_out_ready   o_out_data (value_out status
//                                                  steps_left)
//
// load, read, unused code or ignored shuffle step: decode, then post the result
// swapping shuffle step: waits on the bit-serial remainder unit, then the read-swap-write
//   on the store's read and write ports; no beat is taken until the last result is posted
// reset clears entry count, position, controller state and output valid, not the store
// a held result does not block the next input beat; a second result waits in the
//   controller, and the input stalls, until the first is taken
module fisher_yates_shuffle_core #(
    parameter int DEPTH      = fys_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = fys_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fys_pkg::t_in_beat  i_in_data,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fys_pkg::t_out_beat o_out_data
);

    // command and status between controller and datapath
    fys_pkg::t_cmd  w_cmd;
    fys_pkg::t_stat w_stat;

    // sequencer: accept, decode, optional remainder run and swap, post result
    fys_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // store, count and position registers, remainder unit, output register
    fys_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
